### hw/rtl/assert_macros.svh
// assertion macros used by the command queue of the deframer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hw/rtl/hdf_pkg.sv
// shared constants, command type and crc step for the async hdlc deframer
package hdf_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_GOOD  = 16'hF0B8;

  localparam logic [2:0] ST_GOOD     = 3'd0;
  localparam logic [2:0] ST_BADFCS   = 3'd1;
  localparam logic [2:0] ST_SHORT    = 3'd2;
  localparam logic [2:0] ST_ABORT    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic [15:0] MAX_FRAME_RESET = 16'd2048;
  localparam logic [15:0] MIN_FRAME_BYTES = 16'd2;

  // register index, taken from byte address bit 2
  localparam logic REG_MAX_FRAME = 1'b0;
  localparam int   CFG_ADDR_W    = 3;

  // command queue depth, range 2 to 8
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic       is_end;     // end of frame, else data byte
    logic       emit;       // data byte pushes out the oldest held byte
    logic       check_fcs;  // end status decided by the crc residue
    logic [2:0] status;     // end status when no fcs check is needed
    logic [7:0] data;       // unescaped data byte
  } hdf_cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/hdf_front.sv
// front end: unescaping, byte counting, overflow flush and command issue
module hdf_front
  import hdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] max_frame_bytes,
  output logic        push,
  output hdf_cmd_t    cmd
);

  logic        escape_pending, escape_pending_next;
  logic        flushing, flushing_next;
  logic [15:0] byte_count, byte_count_next;
  logic        active;
  logic [7:0]  data_val;

  assign active = escape_pending | flushing | (byte_count != 16'd0);

  always_comb begin
    escape_pending_next = escape_pending;
    flushing_next       = flushing;
    byte_count_next     = byte_count;
    push                = 1'b0;
    data_val            = escape_pending ? (rx_byte ^ ESC_XOR) : rx_byte;
    cmd.is_end          = 1'b0;
    cmd.emit            = byte_count >= MIN_FRAME_BYTES;
    cmd.check_fcs       = 1'b0;
    cmd.status          = ST_GOOD;
    cmd.data            = data_val;
    if (rx_byte == FLAG_BYTE) begin
      escape_pending_next = 1'b0;
      flushing_next       = 1'b0;
      byte_count_next     = 16'd0;
      push                = active;
      cmd.is_end          = 1'b1;
      cmd.emit            = 1'b0;
      cmd.data            = 8'h00;
      priority if (escape_pending) begin
        cmd.status = ST_ABORT;
      end else if (flushing) begin
        cmd.status = ST_OVERFLOW;
      end else if (byte_count < MIN_FRAME_BYTES) begin
        cmd.status = ST_SHORT;
      end else begin
        cmd.check_fcs = 1'b1;
      end
    end else if (!flushing) begin
      if (!escape_pending && rx_byte == ESC_BYTE) begin
        escape_pending_next = 1'b1;
      end else begin
        escape_pending_next = 1'b0;
        if (byte_count >= max_frame_bytes) begin
          flushing_next = 1'b1;
        end else begin
          byte_count_next = byte_count + 16'd1;
          push            = 1'b1;
        end
      end
    end
    if (!accept) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      flushing       <= 1'b0;
      byte_count     <= 16'd0;
    end else if (accept) begin
      escape_pending <= escape_pending_next;
      flushing       <= flushing_next;
      byte_count     <= byte_count_next;
    end
  end

endmodule

### hw/rtl/hdf_cmd_fifo.sv
// short command queue between front and back
`include "assert_macros.svh"
module hdf_cmd_fifo
  import hdf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  hdf_cmd_t push_cmd,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output hdf_cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hdf_cmd_t           slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_overrun, clk, rst, push && full, "command pushed into a full queue")
  `ASSERT_NEVER(a_no_underrun, clk, rst, pop && !head_valid, "command popped from an empty queue")
  `ASSERT_AT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "queue count above depth")

endmodule

### hw/rtl/hdf_back.sv
// back end: crc accumulation, two byte delay line and output register
module hdf_back
  import hdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  hdf_cmd_t   cmd,
  output logic       take,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       frame_end,
  output logic [2:0] end_status
);

  logic [15:0] crc_accum;
  logic [7:0]  hold0, hold1;

  assign take = cmd_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum <= CRC_INIT;
      out_valid <= 1'b0;
    end else if (take) begin
      if (cmd.is_end) begin
        crc_accum <= CRC_INIT;
        out_valid <= 1'b1;
      end else begin
        crc_accum <= crc_byte(crc_accum, cmd.data);
        out_valid <= cmd.emit;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (cmd.is_end) begin
        data_byte <= 8'h00;
        frame_end <= 1'b1;
        if (cmd.check_fcs) begin
          end_status <= (crc_accum == CRC_GOOD) ? ST_GOOD : ST_BADFCS;
        end else begin
          end_status <= cmd.status;
        end
      end else begin
        hold0      <= hold1;
        hold1      <= cmd.data;
        data_byte  <= hold0;
        frame_end  <= 1'b0;
        end_status <= ST_GOOD;
      end
    end
  end

endmodule

### hw/rtl/ppp_async_hdlc_deframer_top.sv
// top level of the async ppp hdlc deframer with its configuration port
// a result is registered: each command is written into the command queue, then taken into
//   the back end's output register
// throughput: one line byte per cycle while the command queue has room, set by the front
//   state update and the one byte crc step in the back end, with the queue between them
// reset: rst (synchronous) clears frame state, crc, queue and output valid,
//   and sets max_frame_bytes to 2048; no clearing pass
module ppp_async_hdlc_deframer_top
  import hdf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // input byte channel
  input  logic                  rx_valid,
  output logic                  rx_ready,
  input  logic [7:0]            rx_byte,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            data_byte,
  output logic                  frame_end,
  output logic [2:0]            end_status,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [15:0] max_frame_bytes;
  logic        cfg_write;
  logic        rx_accept;
  logic        q_full, q_push, q_pop, q_valid;
  hdf_cmd_t    front_cmd, head_cmd;

  // configuration: one register, decoded on address bit 2, never stalls
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_RESET;
    end else if (cfg_write && paddr[2] == REG_MAX_FRAME) begin
      max_frame_bytes <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_FRAME) ? {16'h0000, max_frame_bytes} : 32'h0;

  // a byte transfers whenever the queue has room, independent of the output side
  assign rx_ready  = !q_full;
  assign rx_accept = rx_valid && rx_ready;

  // front: unescape, count, flush control and command issue
  hdf_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (rx_accept),
    .rx_byte         (rx_byte),
    .max_frame_bytes (max_frame_bytes),
    .push            (q_push),
    .cmd             (front_cmd)
  );

  // queue lets the front keep taking bytes while a result waits
  hdf_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (front_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  // back: crc, delay line and the result register
  hdf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd        (head_cmd),
    .take       (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .frame_end  (frame_end),
    .end_status (end_status)
  );

endmodule

### tb/ppp_async_hdlc_deframer_top_tb.sv
// self-checking testbench for the async ppp hdlc deframer: random framed traffic against a predictor
module ppp_async_hdlc_deframer_top_tb;
  import hdf_pkg::*;

  // no-transfer watchdog, well above the longest receiver hold-off plus a sender gap
  localparam int IDLE_LIMIT      = 3000;
  // settle time after the last expected result
  localparam int DRAIN_CYCLES    = 8;
  // one long receiver hold-off so the command queue fills and rx_ready drops
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER  = 400;

  localparam logic [CFG_ADDR_W-1:0] MAX_FRAME_ADDR = {REG_MAX_FRAME, 2'b00};

  // one result item as seen on the output channel
  typedef struct {
    logic [7:0] data;
    logic       is_end;
    logic [2:0] status;
  } deframe_item_t;

  // tracks deframer state and the results still owed by the block
  class frame_ledger;
    logic [15:0]   max_bytes;
    logic [15:0]   fcs_acc;
    logic [15:0]   n_bytes;
    bit            esc_open;
    bit            dumping;
    logic [7:0]    delay_line [2];
    deframe_item_t due [$];
    int            errors;
    int            results_seen;

    function new();
      max_bytes     = MAX_FRAME_RESET;
      delay_line[0] = '0;
      delay_line[1] = '0;
      errors        = 0;
      results_seen  = 0;
      restart();
    endfunction

    // bit-serial form of the reflected crc-16 step
    static function logic [15:0] fcs16_next(logic [15:0] acc, logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int k = 0; k < 8; k++) begin
        fb = r[0] ^ b[k];
        r  = r >> 1;
        if (fb) begin
          r = r ^ CRC_POLY;
        end
      end
      return r;
    endfunction

    function void restart();
      fcs_acc  = CRC_INIT;
      n_bytes  = '0;
      esc_open = 1'b0;
      dumping  = 1'b0;
    endfunction

    // one accepted line byte: update state, queue the result it causes
    function void take_line_byte(logic [7:0] raw);
      deframe_item_t item;
      logic [7:0]    d;
      bit            busy;
      d = raw;
      if (raw == FLAG_BYTE) begin
        busy        = esc_open || dumping || (n_bytes != 0);
        item.data   = '0;
        item.is_end = 1'b1;
        if (esc_open) begin
          item.status = ST_ABORT;
        end else if (dumping) begin
          item.status = ST_OVERFLOW;
        end else if (n_bytes < MIN_FRAME_BYTES) begin
          item.status = ST_SHORT;
        end else if (fcs_acc != CRC_GOOD) begin
          item.status = ST_BADFCS;
        end else begin
          item.status = ST_GOOD;
        end
        restart();
        // back-to-back flags are idle fill
        if (busy) begin
          due.push_back(item);
        end
        return;
      end
      if (dumping) begin
        return;
      end
      if (esc_open) begin
        d        = raw ^ ESC_XOR;
        esc_open = 1'b0;
      end else if (raw == ESC_BYTE) begin
        esc_open = 1'b1;
        return;
      end
      if (n_bytes >= max_bytes) begin
        dumping = 1'b1;
        return;
      end
      fcs_acc = fcs16_next(fcs_acc, d);
      // two-byte delay line holds back the trailing fcs
      if (n_bytes >= MIN_FRAME_BYTES) begin
        item.data   = delay_line[0];
        item.is_end = 1'b0;
        item.status = '0;
        due.push_back(item);
      end
      delay_line[0] = delay_line[1];
      delay_line[1] = d;
      n_bytes       = n_bytes + 16'd1;
    endfunction

    // compare one output transfer against the oldest owed result
    function void match_output(logic [7:0] d, logic e, logic [2:0] s);
      deframe_item_t want;
      results_seen++;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result data_byte=%02h frame_end=%0b end_status=%0d",
                 $time, d, e, s);
        return;
      end
      want = due.pop_front();
      if (d !== want.data) begin
        errors++;
        $display("%0t: data_byte expected %02h, got %02h", $time, want.data, d);
      end
      if (e !== want.is_end) begin
        errors++;
        $display("%0t: frame_end expected %0b, got %0b", $time, want.is_end, e);
      end
      if (s !== want.status) begin
        errors++;
        $display("%0t: end_status expected %0d, got %0d", $time, want.status, s);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  rx_valid;
  logic                  rx_ready;
  logic [7:0]            rx_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            data_byte;
  logic                  frame_end;
  logic [2:0]            end_status;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  frame_ledger ledger = new();

  // line bytes waiting to be offered, and sender bookkeeping
  logic [7:0] line_q [$];
  int         items_sent = 0;
  int         burst_left = 0;

  // receiver idling state
  int         stall_left = 0;
  int         calm_left  = 0;
  bit         held_off   = 1'b0;

  int         quiet = 0;

  ppp_async_hdlc_deframer_top dut (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .frame_end  (frame_end),
    .end_status (end_status),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap before the next input transfer: mostly none, now and then a long one,
  // with occasional bursts of back-to-back transfers
  function automatic int sender_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // offer one byte, hold it until the transfer, then tell the predictor
  task automatic offer_byte(logic [7:0] b);
    int gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      rx_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid = 1'b1;
    rx_byte  = b;
    do @(posedge clk); while (!rx_ready);
    items_sent++;
    ledger.take_line_byte(b);
  endtask

  task automatic offer_line();
    while (line_q.size() > 0) begin
      offer_byte(line_q.pop_front());
    end
  endtask

  // byte stuffing; spare escapes of ordinary bytes are legal on the line,
  // but never for the byte whose escaped form is the flag
  function automatic void stuff_byte(logic [7:0] d, bit spare_esc);
    if (d == FLAG_BYTE || d == ESC_BYTE ||
        (spare_esc && d != (FLAG_BYTE ^ ESC_XOR) && $urandom_range(9) == 0)) begin
      line_q.push_back(ESC_BYTE);
      line_q.push_back(d ^ ESC_XOR);
    end else begin
      line_q.push_back(d);
    end
  endfunction

  // payload plus fcs (low byte first) plus closing flag; a non-zero flip spoils the fcs
  function automatic void frame_to_line(logic [7:0] body [$], logic [15:0] fcs_flip);
    logic [15:0] acc;
    logic [15:0] fcs;
    acc = CRC_INIT;
    foreach (body[i]) begin
      acc = frame_ledger::fcs16_next(acc, body[i]);
      stuff_byte(body[i], 1'b1);
    end
    fcs = ~acc ^ fcs_flip;
    stuff_byte(fcs[7:0], 1'b1);
    stuff_byte(fcs[15:8], 1'b1);
    line_q.push_back(FLAG_BYTE);
  endfunction

  // mostly well-formed frames, the rest bad fcs, aborts, runts and raw noise
  task automatic send_random_frame();
    logic [7:0] body [$];
    int         roll;
    int         len;
    int         pick;
    roll = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 10);
    if ($urandom_range(3) == 0) begin
      line_q.push_back(FLAG_BYTE);
    end
    repeat (len) body.push_back(8'($urandom));
    if (roll < 65) begin
      frame_to_line(body, '0);
    end else if (roll < 75) begin
      frame_to_line(body, 16'($urandom_range(1, 16'hFFFF)));
    end else if (roll < 83) begin
      foreach (body[i]) stuff_byte(body[i], 1'b1);
      line_q.push_back(ESC_BYTE);
      line_q.push_back(FLAG_BYTE);
    end else if (roll < 90) begin
      repeat ($urandom_range(0, 1)) stuff_byte(8'($urandom), 1'b1);
      line_q.push_back(FLAG_BYTE);
    end else begin
      repeat ($urandom_range(1, 8)) begin
        pick = $urandom_range(99);
        line_q.push_back(pick < 15 ? FLAG_BYTE : pick < 30 ? ESC_BYTE : 8'($urandom));
      end
    end
    offer_line();
  endtask

  task automatic run_traffic(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      send_random_frame();
    end
  endtask

  // sender pauses until every owed result has come out, then lets the pipe settle
  task automatic wait_drained();
    @(negedge clk);
    rx_valid = 1'b0;
    while (ledger.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write (setup then access), followed by a read-back
  task automatic write_max(logic [15:0] v);
    wait_drained();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = MAX_FRAME_ADDR;
    pwdata  = {16'h0000, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    ledger.max_bytes = v;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== v) begin
      ledger.errors++;
      $display("%0t: max_frame_bytes read-back expected %04h, got %04h", $time, v, prdata[15:0]);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // output side: random stalls, quiet stretches, and one long hold-off while the
  // sender keeps offering so the block backs up to its input
  initial begin
    int roll;
    forever begin
      @(negedge clk);
      if (!held_off && rx_valid && ledger.results_seen >= HOLD_OFF_AFTER) begin
        held_off   = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_ready = 1'b1;
      end else begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          calm_left = $urandom_range(30, 120);
        end else if (roll < 20) begin
          stall_left = $urandom_range(1, 3);
        end else if (roll < 23) begin
          stall_left = $urandom_range(15, 50);
        end
        out_ready = (stall_left == 0);
      end
    end
  end

  // every output transfer is checked at the edge that completes it
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      ledger.match_output(data_byte, frame_end, end_status);
    end
  end

  // watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst || (rx_valid && rx_ready) || (out_valid && out_ready) || psel) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [7:0] body [$];
    rst       = 1'b1;
    rx_valid  = 1'b0;
    rx_byte   = '0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed: idle flags, then a good frame whose payload needs both escapes
    line_q = {FLAG_BYTE, FLAG_BYTE};
    body   = {FLAG_BYTE, ESC_BYTE, 8'hFF, 8'h00};
    frame_to_line(body, '0);
    // empty payload with its fcs: good, but nothing streams out
    body = {};
    frame_to_line(body, '0);
    // bad fcs, then a runt
    body = {8'h01, 8'h02, 8'h03};
    frame_to_line(body, 16'h0001);
    line_q = {line_q, 8'h55, FLAG_BYTE};
    // escape straight before the flag, with and without data in front
    line_q = {line_q, ESC_BYTE, FLAG_BYTE};
    line_q = {line_q, 8'hAA, ESC_BYTE, 8'h31, 8'hBB, ESC_BYTE, FLAG_BYTE};
    offer_line();

    run_traffic(300);

    // smallest maximum: only empty-payload frames survive
    write_max(MIN_FRAME_BYTES);
    run_traffic(250);
    write_max(16'd3);
    run_traffic(200);

    // lower the maximum inside an open frame; the flush starts at the next data byte
    // and swallows the escape before the flag
    write_max(16'd2048);
    repeat (5) stuff_byte(8'($urandom), 1'b0);
    offer_line();
    write_max(MIN_FRAME_BYTES);
    line_q = {8'h11, ESC_BYTE, 8'h22, FLAG_BYTE};
    offer_line();

    write_max(16'd24);
    run_traffic(250);
    write_max(16'hFFFF);
    run_traffic(300);
    write_max(16'($urandom_range(4, 40)));
    run_traffic(250);

    // all stimulus in: wait for the last owed result, then let the pipe settle
    @(negedge clk);
    rx_valid = 1'b0;
    while (ledger.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
